/* design/efr_pkg.sv */
// shared types and constants for the escaped frame receiver
`default_nettype none
package efr_pkg;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int LEN_W       = 9;
   localparam int CSR_IDX_W   = 2;

   localparam int MAX_FRAME_BYTES_DEFAULT = 512;

   localparam logic [BYTE_W-1:0] FLAG_VALUE_RESET         = 8'h7e;
   localparam logic [BYTE_W-1:0] ESCAPE_VALUE_RESET       = 8'h7d;
   localparam logic [BYTE_W-1:0] FLAG_ESCAPE_CODE_RESET   = 8'h02;
   localparam logic [BYTE_W-1:0] ESCAPE_ESCAPE_CODE_RESET = 8'h01;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLAG_VALUE         = 2'd0,
      CSR_ESCAPE_VALUE       = 2'd1,
      CSR_FLAG_ESCAPE_CODE   = 2'd2,
      CSR_ESCAPE_ESCAPE_CODE = 2'd3
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      EV_BYTE       = 2'd0,
      EV_DONE       = 2'd1,
      EV_BAD_ESCAPE = 2'd2,
      EV_OVERFLOW   = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_value;
      logic [BYTE_W-1:0] escape_value;
      logic [BYTE_W-1:0] flag_escape_code;
      logic [BYTE_W-1:0] escape_escape_code;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      event_kind_type    kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

endpackage
`default_nettype wire

/* design/efr_csr.sv */
// configuration registers of the escaped frame receiver
`default_nettype none
module efr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [efr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [efr_pkg::BYTE_W-1:0]     csr_write_data,
   output efr_pkg::cfg_type                    cfg
);
   import efr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FLAG_VALUE:         cfg_in.flag_value         = csr_write_data;
            CSR_ESCAPE_VALUE:       cfg_in.escape_value       = csr_write_data;
            CSR_FLAG_ESCAPE_CODE:   cfg_in.flag_escape_code   = csr_write_data;
            CSR_ESCAPE_ESCAPE_CODE: cfg_in.escape_escape_code = csr_write_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value         <= FLAG_VALUE_RESET;
         cfg_ff.escape_value       <= ESCAPE_VALUE_RESET;
         cfg_ff.flag_escape_code   <= FLAG_ESCAPE_CODE_RESET;
         cfg_ff.escape_escape_code <= ESCAPE_ESCAPE_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* design/efr_core.sv */
// framing state and per-byte decode of the escaped frame receiver
`default_nettype none
module efr_core #(
   parameter int MAX_FRAME_BYTES = efr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [efr_pkg::BYTE_W-1:0]  rx_byte,
   input  wire efr_pkg::cfg_type            cfg,
   output efr_pkg::result_type              result
);
   import efr_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME_BYTES - 1);

   logic             in_frame_ff, in_frame_in;
   logic             escape_pending_ff, escape_pending_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic              store;
   logic [BYTE_W-1:0] store_byte;
   logic [CNT_W-1:0]  len_full;

   assign len_full = count_ff - CNT_ONE;

   always_comb begin
      in_frame_in       = in_frame_ff;
      escape_pending_in = escape_pending_ff;
      count_in          = count_ff;
      store             = 1'b0;
      store_byte        = rx_byte;
      result            = '{valid: 1'b0, kind: EV_BYTE, payload_byte: '0, frame_length: '0};

      if (!in_frame_ff) begin
         // hunting: only the flag counts
         if (rx_byte == cfg.flag_value) begin
            in_frame_in       = 1'b1;
            escape_pending_in = 1'b0;
            count_in          = CNT_ONE;
         end
      end else if (escape_pending_ff) begin
         escape_pending_in = 1'b0;
         if (rx_byte == cfg.flag_escape_code) begin
            store      = 1'b1;
            store_byte = cfg.flag_value;
         end else if (rx_byte == cfg.escape_escape_code) begin
            store      = 1'b1;
            store_byte = cfg.escape_value;
         end else begin
            in_frame_in  = 1'b0;
            count_in     = '0;
            result.valid = 1'b1;
            result.kind  = EV_BAD_ESCAPE;
         end
      end else if (rx_byte == cfg.escape_value) begin
         escape_pending_in = 1'b1;
      end else if (rx_byte == cfg.flag_value) begin
         // empty frame keeps the frame open
         if (count_ff != CNT_ONE) begin
            in_frame_in         = 1'b0;
            count_in            = '0;
            result.valid        = 1'b1;
            result.kind         = EV_DONE;
            result.frame_length = LEN_W'(len_full);
         end
      end else begin
         store = 1'b1;
      end

      if (store) begin
         result.valid = 1'b1;
         if (count_ff == CNT_LIMIT) begin
            in_frame_in       = 1'b0;
            escape_pending_in = 1'b0;
            count_in          = '0;
            result.kind       = EV_OVERFLOW;
         end else begin
            count_in            = count_ff + CNT_ONE;
            result.kind         = EV_BYTE;
            result.payload_byte = store_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff       <= 1'b0;
         escape_pending_ff <= 1'b0;
         count_ff          <= '0;
      end else if (step) begin
         in_frame_ff       <= in_frame_in;
         escape_pending_ff <= escape_pending_in;
         count_ff          <= count_in;
      end
   end

endmodule
`default_nettype wire

/* design/escaped_frame_receiver_unit.sv */
// top level of the escaped frame receiver: input register, decode, result register
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall rx_byte
//   rsp      out        rsp_valid/rsp_stall event_kind, payload_byte, frame_length
//   csr      in         csr_write_enable    csr_index, csr_write_data
//
// one item per cycle unless stalled; items pass the input, then the result register
// the decode between input and result register is a few byte compares and one count increment
// a byte that yields no result still passes through and updates the framing state
// reset (synchronous) empties both registers, restores the register defaults and starts hunting
// rsp_stall holds the result register; req_stall rises only while the input register is full
// and cannot move on, so a waiting result does not block the item behind it until both are full
`default_nettype none
module escaped_frame_receiver_unit #(
   parameter int MAX_FRAME_BYTES = efr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // item input
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [efr_pkg::BYTE_W-1:0]     req_rx_byte,
   // result output
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [efr_pkg::KIND_W-1:0]          rsp_event_kind,
   output logic [efr_pkg::BYTE_W-1:0]          rsp_payload_byte,
   output logic [efr_pkg::LEN_W-1:0]           rsp_frame_length,
   // configuration
   input  wire logic                           csr_write_enable,
   input  wire logic [efr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [efr_pkg::BYTE_W-1:0]     csr_write_data
);
   import efr_pkg::*;

   cfg_type    cfg;
   result_type result;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   event_kind_type    rsp_kind_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [LEN_W-1:0]  rsp_len_ff;

   logic advance;   // result register free or being emptied this cycle
   logic step;      // the held item is decoded this cycle
   logic accept;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   efr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   efr_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // input register keeps its item while stalled, else takes whatever is offered
   assign in_valid_in = req_stall ? 1'b1 : req_valid;

   // result register reloads whenever it can advance
   assign rsp_valid_in = advance ? (step && result.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step && result.valid) begin
         rsp_kind_ff <= result.kind;
         rsp_byte_ff <= result.payload_byte;
         rsp_len_ff  <= result.frame_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_frame_length = rsp_len_ff;

   // a held item is never dropped while the result side is stalled
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("item lost from input register");

   // input stalls only when an item is waiting behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without cause");

   // only payload items carry a byte, only completed frames carry a length
   a_field_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_kind == EV_BYTE || rsp_payload_byte == '0) &&
                     (rsp_event_kind == EV_DONE || rsp_frame_length == '0)))
      else $error("result field set for wrong event kind");

   // a decoded item with a result always lands in the result register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (step && result.valid) |=> rsp_valid_ff)
      else $error("result not registered");

endmodule
`default_nettype wire

/* sim/escaped_frame_receiver_unit_test.sv */
// self-checking testbench of the escaped frame receiver: byte stimulus, event prediction, checks
`default_nettype none
module escaped_frame_receiver_unit_test;
   import efr_pkg::*;

   // the block runs at its default buffer limit, so the longest frames reach full length
   localparam int FRAME_LIMIT = MAX_FRAME_BYTES_DEFAULT;

   // expected events hold all three fields, unused ones at zero
   typedef struct packed {
      event_kind_type    kind;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  length;
   } frame_event_type;

   // tracks the framing state of the stream and the events it should produce
   class frame_event_tracker;
      logic [BYTE_W-1:0] flag_v;
      logic [BYTE_W-1:0] esc_v;
      logic [BYTE_W-1:0] flag_code;
      logic [BYTE_W-1:0] esc_code;
      bit                open;
      bit                esc_seen;
      int unsigned       held;
      int unsigned       frame_limit;
      frame_event_type   due_events[$];
      int                errors;
      int unsigned       live_items;

      function new(int unsigned limit);
         frame_limit = limit;
         flag_v      = FLAG_VALUE_RESET;
         esc_v       = ESCAPE_VALUE_RESET;
         flag_code   = FLAG_ESCAPE_CODE_RESET;
         esc_code    = ESCAPE_ESCAPE_CODE_RESET;
         errors      = 0;
         live_items  = 0;
         close_frame();
      endfunction

      function void set_reg(csr_index_type idx, logic [BYTE_W-1:0] v);
         case (idx)
            CSR_FLAG_VALUE:         flag_v    = v;
            CSR_ESCAPE_VALUE:       esc_v     = v;
            CSR_FLAG_ESCAPE_CODE:   flag_code = v;
            CSR_ESCAPE_ESCAPE_CODE: esc_code  = v;
            default: ;
         endcase
      endfunction

      function void close_frame();
         open     = 1'b0;
         esc_seen = 1'b0;
         held     = 0;
      endfunction

      function void push_event(event_kind_type k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l);
         frame_event_type ev;
         ev.kind   = k;
         ev.data   = d;
         ev.length = l;
         due_events.push_back(ev);
      endfunction

      // a recovered byte, plain or unescaped
      function void store_byte(logic [BYTE_W-1:0] b);
         held++;
         if (held >= frame_limit) begin
            close_frame();
            push_event(EV_OVERFLOW, '0, '0);
         end else begin
            push_event(EV_BYTE, b, '0);
         end
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         logic [LEN_W-1:0] len;
         if (!open) begin
            if (b == flag_v) begin
               open       = 1'b1;
               esc_seen   = 1'b0;
               held       = 1;
               live_items++;
            end
            return;
         end
         live_items++;
         // a pending escape takes precedence over everything else
         if (esc_seen) begin
            esc_seen = 1'b0;
            if (b == flag_code) store_byte(flag_v);
            else if (b == esc_code) store_byte(esc_v);
            else begin
               close_frame();
               push_event(EV_BAD_ESCAPE, '0, '0);
            end
            return;
         end
         if (b == esc_v) begin
            esc_seen = 1'b1;
            return;
         end
         if (b == flag_v) begin
            // back to back flags keep the frame open without an event
            if (held == 1) return;
            len = LEN_W'(held - 1);
            close_frame();
            push_event(EV_DONE, '0, len);
            return;
         end
         store_byte(b);
      endfunction

      function int pending();
         return due_events.size();
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         if (errors <= 100)
            $display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
      endtask

      task check_event(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                       logic [LEN_W-1:0] length);
         frame_event_type want;
         if (due_events.size() == 0) begin
            report_mismatch("result with nothing expected", int'(kind), 0);
            return;
         end
         want = due_events.pop_front();
         if (kind !== want.kind)
            report_mismatch("event kind", int'(kind), int'(want.kind));
         if (data !== want.data)
            report_mismatch("payload byte", int'(data), int'(want.data));
         if (length !== want.length)
            report_mismatch("frame length", int'(length), int'(want.length));
      endtask
   endclass

   // every input starts at a known value
   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [KIND_W-1:0]    rsp_event_kind;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic [LEN_W-1:0]     rsp_frame_length;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [BYTE_W-1:0]    csr_write_data   = '0;

   // pacing, in percent per cycle
   int send_pct = 0;
   int recv_pct = 0;

   // long receiver hold-off: main bumps the token, the stall process counts the cycles
   int hold_token = 0;
   int hold_seen  = 0;
   int hold_left  = 0;

   frame_event_tracker sb = new(FRAME_LIMIT);

   escaped_frame_receiver_unit #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_length (rsp_frame_length),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // generous ceiling on the whole run
   initial begin
      #500000;
      $display("[escaped_frame_receiver_unit] ERROR");
      $finish;
   end

   // receiver side: random stall, overridden by a long hold-off when asked
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = 150;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_pct);
      end
   end

   // a result is taken at an edge with valid high and stall low
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_event(rsp_event_kind, rsp_payload_byte, rsp_frame_length);
   end

   // offer one byte, with random idle cycles ahead of it, and hold it until taken
   task automatic offer(input logic [BYTE_W-1:0] b);
      while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_byte(b);
   endtask

   // let the block empty out, then allow for bytes that are still in flight without a result
   task automatic drain_block();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [BYTE_W-1:0] f, e, fc, ec);
      csr_index_type     regs [4];
      logic [BYTE_W-1:0] vals [4];
      regs = '{CSR_FLAG_VALUE, CSR_ESCAPE_VALUE, CSR_FLAG_ESCAPE_CODE, CSR_ESCAPE_ESCAPE_CODE};
      vals = '{f, e, fc, ec};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= regs[i];
         csr_write_data   <= vals[i];
         @(posedge clock);
         sb.set_reg(regs[i], vals[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   // a third of the bytes hit one of the programmed values
   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 11))
         0: return sb.flag_v;
         1: return sb.esc_v;
         2: return sb.flag_code;
         3: return sb.esc_code;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // well-formed frame of n recovered bytes, stuffed where needed, now and then a stray escape
   task automatic send_frame(input int n, input bit strays = 1'b1);
      logic [BYTE_W-1:0] b;
      offer(sb.flag_v);
      for (int i = 0; i < n; i++) begin
         b = pick_byte();
         if (strays && $urandom_range(0, 59) == 0) begin
            offer(sb.esc_v);
            offer(pick_byte());
         end else if (b == sb.flag_v || b == sb.esc_v) begin
            offer(sb.esc_v);
            offer(b == sb.flag_v ? sb.flag_code : sb.esc_code);
         end else begin
            offer(b);
         end
      end
      offer(sb.flag_v);
   endtask

   // mostly well-formed frames, some line noise, some frames cut short by an escape
   task automatic run_traffic(input int target);
      int unsigned goal;
      int          r;
      goal = sb.live_items + target;
      while (sb.live_items < goal) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            repeat ($urandom_range(1, 4)) offer(BYTE_W'($urandom_range(0, 255)));
         end else if (r < 14) begin
            offer(sb.flag_v);
            repeat ($urandom_range(0, 3)) offer(pick_byte());
            offer(sb.esc_v);
            offer(pick_byte());
         end else begin
            send_frame(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset register values
      // bytes while hunting are ignored, escapes and codes included
      offer(8'h00); offer(8'hff); offer(8'h7d); offer(8'h02);
      // empty frame reopen, extreme bytes, both escapes, close with length four
      offer(8'h7e); offer(8'h7e); offer(8'h00); offer(8'hff);
      offer(8'h7d); offer(8'h02); offer(8'h7d); offer(8'h01); offer(8'h7e);
      // flag straight after an escape is a bad escape
      offer(8'h7e); offer(8'h41); offer(8'h7d); offer(8'h7e);
      // escape after escape, then an unknown code
      offer(8'h7e); offer(8'h7d); offer(8'h7d);
      offer(8'h7e); offer(8'h7d); offer(8'h55);
      // single byte frame
      offer(8'h7e); offer(8'h80); offer(8'h7e);
      drain_block();

      // random registers, no idling; receiver holds off while the sender keeps pushing
      write_cfg(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      send_pct = 0; recv_pct = 0;
      hold_token = hold_token + 1;
      send_frame(40);
      drain_block();
      run_traffic(50);
      drain_block();

      // extremes of the register range, sender idling
      write_cfg(8'h00, 8'hff, 8'hff, 8'h00);
      send_pct = 86; recv_pct = 0;
      run_traffic(50);
      drain_block();

      // opposite extremes, receiver stalling, one frame that overflows the buffer
      write_cfg(8'hff, 8'h00, 8'h00, 8'hff);
      send_pct = 0; recv_pct = 86;
      send_frame(FRAME_LIMIT - 1, 1'b0);
      run_traffic(50);
      drain_block();

      // flag equal to escape and the two codes equal, both sides idling
      write_cfg(8'ha5, 8'ha5, 8'h3c, 8'h3c);
      send_pct = 28; recv_pct = 28;
      run_traffic(50);
      drain_block();

      // codes equal to the flag and escape values themselves
      write_cfg(8'h7e, 8'h7d, 8'h7e, 8'h7d);
      send_pct = 86; recv_pct = 0;
      run_traffic(50);
      drain_block();

      write_cfg(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      send_pct = 0; recv_pct = 86;
      run_traffic(50);
      drain_block();

      // back to the usual values written explicitly
      write_cfg(FLAG_VALUE_RESET, ESCAPE_VALUE_RESET, FLAG_ESCAPE_CODE_RESET,
                ESCAPE_ESCAPE_CODE_RESET);
      send_pct = 28; recv_pct = 28;
      run_traffic(50);
      drain_block();

      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("expected results never arrived", sb.pending(), 0);
      if (sb.errors == 0) begin
         $display("[escaped_frame_receiver_unit] OK");
      end else begin
         $display("[escaped_frame_receiver_unit] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
design/efr_pkg.sv
design/efr_csr.sv
design/efr_core.sv
design/escaped_frame_receiver_unit.sv
sim/escaped_frame_receiver_unit_test.sv
